FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion shorthands for clocked implication checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/glu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glu_pkg
// Types and constants shared by the gcd/lcm unit and its checker.
// ----------------------------------------------------------------------------
package glu_pkg;

   localparam int OPERAND_BITS_DEF = 31;
   localparam int RESULT_BITS      = 62;
   // Room for a full product of two 32-bit operands.
   localparam int PROD_EXT_BITS    = 64;

   localparam logic MODE_GCD = 1'b0;
   localparam logic MODE_LCM = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GCD,
      ST_DIV,
      ST_MUL
   } glu_state_type;

endpackage

FILE: sv/gcd_lcm_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_lcm_unit
// Greatest common divisor (mode 0) or least common multiple (mode 1) of two
// unsigned operands, computed by one shared add/subtract unit under a
// small sequencer.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy then stays high
// until the result has been issued. The result appears on rsp_result for a
// single cycle with rsp_valid high and must be captured then. The gcd runs
// as a binary (shift and subtract) search of at most 2*OPERAND_BITS steps,
// one step per clock; an lcm adds a restoring division a/gcd and a
// shift-add multiply by b, all on the same OPERAND_BITS+2 bit adder; an
// lcm with a zero operand returns 0 on the next clock without raising busy.
// An lcm above 2^62-1 (possible only at 32-bit operands) saturates.
// ----------------------------------------------------------------------------
module gcd_lcm_unit #(
   parameter int OPERAND_BITS = glu_pkg::OPERAND_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_mode,
   input  logic [OPERAND_BITS-1:0]         req_operand_a,
   input  logic [OPERAND_BITS-1:0]         req_operand_b,
   output logic                            rsp_valid,
   output logic [glu_pkg::RESULT_BITS-1:0] rsp_result
);

   localparam int W        = OPERAND_BITS;
   localparam int CNT_BITS = $clog2(W);
   localparam int RB       = glu_pkg::RESULT_BITS;
   localparam int PB       = glu_pkg::PROD_EXT_BITS;

   glu_pkg::glu_state_type state_ff, state_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [RB-1:0]       rsp_result_ff, rsp_result_in;
   logic                mode_ff, mode_in;
   logic [W-1:0]        a_ff, a_in;
   logic [W-1:0]        b_ff, b_in;
   logic [W-1:0]        u_ff, u_in;
   logic [W-1:0]        v_ff, v_in;
   logic [CNT_BITS-1:0] k_ff, k_in;
   logic [W-1:0]        g_ff, g_in;
   logic [W-1:0]        rem_ff, rem_in;   // remainder, then product high half
   logic [W-1:0]        quo_ff, quo_in;   // quotient, then product low half
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   // shared adder / subtractor
   logic          alu_sub;
   logic [W:0]    alu_x, alu_y;
   logic [W+1:0]  alu_sum;

   logic          u_ge_v;
   logic          cnt_last;
   logic [W-1:0]  gcd_val;
   logic [W:0]    mul_sum;
   logic [W-1:0]  mul_hi, mul_lo;
   logic [PB-1:0] prod_ext;
   logic          prod_sat;

   assign u_ge_v   = (u_ff >= v_ff);
   assign cnt_last = (cnt_ff == CNT_BITS'(W - 1));
   assign gcd_val  = W'((u_ff | v_ff) << k_ff);

   always_comb begin
      alu_sub = 1'b1;
      alu_x   = '0;
      alu_y   = '0;
      unique case (state_ff)
         glu_pkg::ST_GCD: begin
            alu_x = u_ge_v ? {1'b0, u_ff} : {1'b0, v_ff};
            alu_y = u_ge_v ? {1'b0, v_ff} : {1'b0, u_ff};
         end
         glu_pkg::ST_DIV: begin
            alu_x = {rem_ff, quo_ff[W-1]};
            alu_y = {1'b0, g_ff};
         end
         glu_pkg::ST_MUL: begin
            alu_sub = 1'b0;
            alu_x   = {1'b0, rem_ff};
            alu_y   = {1'b0, b_ff};
         end
         default: begin
            alu_sub = 1'b1;
         end
      endcase
   end

   // in subtract mode the top bit is set when x >= y
   assign alu_sum = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)}
                    + (W+2)'(alu_sub);

   // shift-add multiply step: add b when the low multiplier bit is set
   assign mul_sum  = quo_ff[0] ? alu_sum[W:0] : {1'b0, rem_ff};
   assign mul_hi   = mul_sum[W:1];
   assign mul_lo   = {mul_sum[0], quo_ff[W-1:1]};
   assign prod_ext = PB'({mul_hi, mul_lo});
   assign prod_sat = |prod_ext[PB-1:RB];

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = 1'b0;
      rsp_result_in = rsp_result_ff;
      mode_in       = mode_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      k_in          = k_ff;
      g_in          = g_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      unique case (state_ff)
         glu_pkg::ST_IDLE: begin
            if (start) begin
               mode_in = req_mode;
               a_in    = req_operand_a;
               b_in    = req_operand_b;
               u_in    = req_operand_a;
               v_in    = req_operand_b;
               k_in    = '0;
               if (req_mode == glu_pkg::MODE_LCM &&
                   (req_operand_a == '0 || req_operand_b == '0)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_result_in = '0;
               end else begin
                  state_in = glu_pkg::ST_GCD;
               end
            end
         end
         glu_pkg::ST_GCD: begin
            if (u_ff == '0 || v_ff == '0) begin
               g_in = gcd_val;
               if (mode_ff == glu_pkg::MODE_GCD) begin
                  rsp_valid_in  = 1'b1;
                  rsp_result_in = RB'(gcd_val);
                  state_in      = glu_pkg::ST_IDLE;
               end else begin
                  rem_in   = '0;
                  quo_in   = a_ff;
                  cnt_in   = '0;
                  state_in = glu_pkg::ST_DIV;
               end
            end else if (!u_ff[0] && !v_ff[0]) begin
               // common factor of two: strip it and count it
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ge_v) begin
               u_in = alu_sum[W:1];
            end else begin
               v_in = alu_sum[W:1];
            end
         end
         glu_pkg::ST_DIV: begin
            quo_in = {quo_ff[W-2:0], alu_sum[W+1]};
            rem_in = alu_sum[W+1] ? alu_sum[W-1:0] : {rem_ff[W-2:0], quo_ff[W-1]};
            if (cnt_last) begin
               // quotient stays in quo as the multiplier
               rem_in   = '0;
               cnt_in   = '0;
               state_in = glu_pkg::ST_MUL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         glu_pkg::ST_MUL: begin
            rem_in = mul_hi;
            quo_in = mul_lo;
            if (cnt_last) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = prod_sat ? '1 : prod_ext[RB-1:0];
               state_in      = glu_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = glu_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= glu_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_ff <= rsp_result_in;
      mode_ff       <= mode_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      u_ff          <= u_in;
      v_ff          <= v_in;
      k_ff          <= k_in;
      g_ff          <= g_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
   end

   assign busy       = (state_ff != glu_pkg::ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

endmodule

FILE: sv/glu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glu_checker
// Port-level checks for the gcd/lcm unit, bound to every instance.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module glu_checker #(
   parameter int OPERAND_BITS = glu_pkg::OPERAND_BITS_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            req_mode,
   input logic [OPERAND_BITS-1:0]         req_operand_a,
   input logic [OPERAND_BITS-1:0]         req_operand_b,
   input logic                            rsp_valid,
   input logic [glu_pkg::RESULT_BITS-1:0] rsp_result
);

   logic accept;
   logic lcm_zero;
   logic rsp_zero;

   assign accept   = start && !busy;
   assign lcm_zero = (req_mode == glu_pkg::MODE_LCM) &&
                     (req_operand_a == '0 || req_operand_b == '0);
   assign rsp_zero = rsp_valid && (rsp_result == '0);

   // an accepted word either occupies the unit or answers at once
   `ASSERT_NEXT(a_accept_progress, clock, reset, accept, busy || rsp_valid, "accepted word lost")

   // lcm with a zero operand answers zero on the next clock
   `ASSERT_NEXT(a_lcm_zero, clock, reset, accept && lcm_zero, rsp_zero, "nonzero lcm of zero")

   // no result without a word in flight
   `ASSERT_SAME(a_no_spurious, clock, reset, rsp_valid, $past(busy || accept), "stray result")

   // leaving the busy state always issues the result
   `ASSERT_SAME(a_done_issues, clock, reset, !$past(reset) && $fell(busy), rsp_valid, "no result")

endmodule

bind gcd_lcm_unit glu_checker #(.OPERAND_BITS(OPERAND_BITS)) u_glu_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_mode      (req_mode),
   .req_operand_a (req_operand_a),
   .req_operand_b (req_operand_b),
   .rsp_valid     (rsp_valid),
   .rsp_result    (rsp_result)
);
